// ===== rtl/cidt_pkg.sv =====
// Shared types and constants for the compact identity to decimal text unit.
// No dependencies; used by cidt_digit_cell and compact_id_to_decimal_text_unit.
`default_nettype none

package cidt_pkg;

   localparam int unsigned NUM_BITS           = 61;
   localparam int unsigned COUNT_WIDTH        = 6;
   localparam int unsigned MAX_DIGITS_DEFAULT = 19;
   localparam int unsigned WORD_WIDTH         = 64;
   localparam int unsigned CHAR_WIDTH         = 6;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = 6'd57;

   typedef struct packed {
      logic clear;
      logic conv;
      logic move;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/cidt_digit_cell.sv =====
// One BCD digit cell of the conversion chain: clear, shift-and-add-3 step, digit move or hold.
// Depends on cidt_pkg for the cell control struct.
`default_nettype none

module cidt_digit_cell (
   input  wire logic                  clock,
   input  wire cidt_pkg::cell_ctl_type ctl,
   input  wire logic                  bit_in,
   input  wire logic [3:0]            digit_in,
   output logic                       bit_out,
   output logic [3:0]                 digit_out
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in_next;
   logic [3:0] adjusted;

   always_comb begin
      adjusted = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
      bit_out  = adjusted[3];
      if (ctl.clear) begin
         digit_in_next = 4'd0;
      end else if (ctl.conv) begin
         digit_in_next = {adjusted[2:0], bit_in};
      end else if (ctl.move) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

   assign digit_out = digit_ff;

endmodule

`default_nettype wire

// ===== rtl/compact_id_to_decimal_text_unit.sv =====
// Top level: converts a compacted identity word into decimal ASCII characters.
// Depends on cidt_pkg and cidt_digit_cell.
// After the accepting edge the unit is busy converting the 61 number bits, then sends the pad
// zeros, then walks the MAX_DIGITS digit positions, skipping leading zero digits and emitting the rest;
// a new word is taken only when idle, and the final character is in the cycle busy falls.
// Each character is on rsp_strobe for one cycle, registered so it appears in the cycle after it is formed; no stall.
// Synchronous active-high reset returns the unit to idle with no transfer pending.
`default_nettype none

module compact_id_to_decimal_text_unit #(
   parameter int unsigned MAX_DIGITS = cidt_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [cidt_pkg::WORD_WIDTH-1:0] req_compact_word,
   output logic                                 rsp_strobe,
   output logic [cidt_pkg::CHAR_WIDTH-1:0]      rsp_text_char,
   output logic                                 rsp_last_char
);

   localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_PAD  = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [cidt_pkg::COUNT_WIDTH-1:0]    bitcnt_ff, bitcnt_in;
   logic [1:0]                          pad_ff, pad_in;
   logic [CW-1:0]                       remain_ff, remain_in;
   logic                                ovf_ff, ovf_in;
   logic [cidt_pkg::NUM_BITS-1:0]       num_ff, num_in;
   logic                                strobe_ff, strobe_in;
   logic [cidt_pkg::CHAR_WIDTH-1:0]     char_ff, char_in;
   logic                                last_ff, last_in;

   cidt_pkg::cell_ctl_type              ctl;
   logic [MAX_DIGITS-1:0]               cell_bit;
   logic [3:0]                          cell_digit [MAX_DIGITS];
   logic [3:0]                          top_digit;

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         cidt_digit_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .bit_in    (num_ff[cidt_pkg::NUM_BITS-1]),
            .digit_in  (4'd0),
            .bit_out   (cell_bit[i]),
            .digit_out (cell_digit[i])
         );
      end else begin : g_next
         cidt_digit_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .bit_in    (cell_bit[i-1]),
            .digit_in  (cell_digit[i-1]),
            .bit_out   (cell_bit[i]),
            .digit_out (cell_digit[i])
         );
      end
   end

   assign top_digit = cell_digit[MAX_DIGITS-1];

   always_comb begin
      state_in  = state_ff;
      bitcnt_in = bitcnt_ff;
      pad_in    = pad_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      num_in    = num_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.clear = 1'b1;
               num_in    = req_compact_word[cidt_pkg::WORD_WIDTH-1:3];
               pad_in    = req_compact_word[2:1];
               bitcnt_in = cidt_pkg::COUNT_WIDTH'(cidt_pkg::NUM_BITS);
               ovf_in    = 1'b0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.conv  = 1'b1;
            num_in    = {num_ff[cidt_pkg::NUM_BITS-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - cidt_pkg::COUNT_WIDTH'(1);
            ovf_in    = ovf_ff | cell_bit[MAX_DIGITS-1];
            if (bitcnt_ff == cidt_pkg::COUNT_WIDTH'(1)) begin
               remain_in = CW'(MAX_DIGITS);
               state_in  = (pad_ff != 2'd0) ? ST_PAD : ST_SKIP;
            end
         end
         ST_PAD: begin
            strobe_in = 1'b1;
            char_in   = cidt_pkg::ASCII_ZERO;
            last_in   = 1'b0;
            pad_in    = pad_ff - 2'd1;
            if (pad_ff == 2'd1) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == 4'd0 && remain_ff > CW'(1) && !ovf_ff) begin
               ctl.move  = 1'b1;
               remain_in = remain_ff - CW'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            char_in   = cidt_pkg::ASCII_ZERO + {2'b00, top_digit};
            last_in   = (remain_ff == CW'(1));
            ctl.move  = 1'b1;
            remain_in = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         bitcnt_ff <= '0;
         pad_ff    <= '0;
         remain_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         bitcnt_ff <= bitcnt_in;
         pad_ff    <= pad_in;
         remain_ff <= remain_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

   a_no_transfer_in_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !strobe_ff)
      else $error("character transfer during conversion");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |-> (state_ff == ST_IDLE && $past(state_ff) == ST_EMIT))
      else $error("final character not at end of digit emission");

   a_char_is_digit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (char_ff >= cidt_pkg::ASCII_ZERO && char_ff <= cidt_pkg::ASCII_NINE))
      else $error("emitted character is not a decimal digit");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SKIP) |->
         (remain_ff != '0 && remain_ff <= CW'(MAX_DIGITS)))
      else $error("digit count out of range");

endmodule

`default_nettype wire

// ===== verif/cidt_text_checker.sv =====
// Checker for compact_id_to_decimal_text_unit: predicts the decimal text of each accepted
// word and compares every character transfer in order. Depends on cidt_pkg.
module cidt_text_checker #(
   parameter int unsigned MAX_DIGITS = cidt_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [cidt_pkg::WORD_WIDTH-1:0] req_compact_word,
   input  logic                            rsp_strobe,
   input  logic [cidt_pkg::CHAR_WIDTH-1:0] rsp_text_char,
   input  logic                            rsp_last_char,
   output int                              error_count,
   output int                              pending_count,
   output int                              chars_checked
);

   typedef struct packed {
      logic [cidt_pkg::CHAR_WIDTH-1:0] text_char;
      logic                            last_char;
   } text_char_type;

   text_char_type expected_chars[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      chars_checked = 0;
   end

   task automatic queue_decimal_text(input logic [cidt_pkg::WORD_WIDTH-1:0] word);
      logic [63:0]                     number;
      logic [1:0]                      pad_count;
      logic [3:0]                      digits[0:19];
      int                              digit_count;
      int                              total;
      int                              k;
      text_char_type                   entry;
      pad_count   = word[2:1];
      number      = {3'b000, word[63:3]};
      digit_count = 0;
      do begin
         digits[digit_count] = 4'(number % 64'd10);
         number              = number / 64'd10;
         digit_count++;
      end while (number != 64'd0 && digit_count < 20);
      if (digit_count > int'(MAX_DIGITS)) begin
         digit_count = int'(MAX_DIGITS);
      end
      total = int'(pad_count) + digit_count;
      k     = 0;
      for (int i = 0; i < int'(pad_count); i++) begin
         entry.text_char = cidt_pkg::ASCII_ZERO;
         entry.last_char = (k == total - 1);
         expected_chars.push_back(entry);
         k++;
      end
      for (int i = digit_count - 1; i >= 0; i--) begin
         entry.text_char = cidt_pkg::ASCII_ZERO + {2'b00, digits[i]};
         entry.last_char = (k == total - 1);
         expected_chars.push_back(entry);
         k++;
      end
   endtask

   always @(posedge clock) begin
      text_char_type oldest;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               $error("character transfer with no expected character: text_char %0d last_char %0d",
                      rsp_text_char, rsp_last_char);
               error_count++;
            end else begin
               oldest = expected_chars.pop_front();
               chars_checked++;
               if (rsp_text_char !== oldest.text_char) begin
                  $error("text_char mismatch: expected %0d, actual %0d",
                         oldest.text_char, rsp_text_char);
                  error_count++;
               end
               if (rsp_last_char !== oldest.last_char) begin
                  $error("last_char mismatch: expected %0d, actual %0d",
                         oldest.last_char, rsp_last_char);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            queue_decimal_text(req_compact_word);
         end
      end
      pending_count = expected_chars.size();
   end

endmodule

// ===== verif/compact_id_to_decimal_text_unit_tb.sv =====
// Testbench top for compact_id_to_decimal_text_unit: drives directed and random identity
// words with random idle gaps and reports the verdict. Depends on cidt_pkg and cidt_text_checker.
module compact_id_to_decimal_text_unit_tb;

   localparam int unsigned MAX_DIGITS   = cidt_pkg::MAX_DIGITS_DEFAULT;
   localparam int          RANDOM_WORDS = 154;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 120;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [cidt_pkg::WORD_WIDTH-1:0] req_compact_word;
   logic                            rsp_strobe;
   logic [cidt_pkg::CHAR_WIDTH-1:0] rsp_text_char;
   logic                            rsp_last_char;
   int                              error_count;
   int                              pending_count;
   int                              chars_checked;
   int                              words_sent;
   int                              cycle_count;
   int                              no_idle_left;

   compact_id_to_decimal_text_unit #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_compact_word (req_compact_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char)
   );

   cidt_text_checker #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_compact_word (req_compact_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .chars_checked    (chars_checked)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("compact_id_to_decimal_text_unit_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [63:0] pack_word(input logic [60:0] number, input logic [1:0] pad,
                                             input logic flag);
      return {number, pad, flag};
   endfunction

   function automatic logic [60:0] power_of_ten(input int exponent);
      logic [60:0] value;
      value = 61'd1;
      for (int i = 0; i < exponent; i++) begin
         value = value * 61'd10;
      end
      return value;
   endfunction

   task automatic idle_gap();
      int pick;
      int cycles;
      pick = $urandom_range(0, 99);
      if (no_idle_left > 0) begin
         no_idle_left--;
         cycles = 0;
      end else if (pick < 5) begin
         no_idle_left = $urandom_range(5, 15);
         cycles       = 0;
      end else if (pick < 45) begin
         cycles = 0;
      end else if (pick < 85) begin
         cycles = $urandom_range(1, 4);
      end else if (pick < 97) begin
         cycles = $urandom_range(5, 40);
      end else begin
         cycles = $urandom_range(60, 200);
      end
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [63:0] word);
      req_compact_word <= word;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      words_sent++;
      idle_gap();
   endtask

   initial begin
      logic [60:0] number;
      logic [63:0] raw;
      int          width;
      int          pick;
      int          waited;
      start            = 1'b0;
      reset            = 1'b1;
      req_compact_word = '0;
      words_sent       = 0;
      no_idle_left     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: zero with every pad, widest number, flag clear and set, digit edges.
      for (int p = 0; p < 4; p++) begin
         send_word(pack_word(61'd0, 2'(p), 1'b0));
      end
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(pack_word({61{1'b1}}, 2'd0, 1'b0));
      send_word(pack_word(power_of_ten(18), 2'd3, 1'b1));
      send_word(pack_word(power_of_ten(18) - 61'd1, 2'd3, 1'b0));
      send_word(pack_word(61'd1, 2'd0, 1'b1));
      send_word(pack_word(61'd9, 2'd1, 1'b0));
      send_word(pack_word(61'd10, 2'd2, 1'b1));
      send_word(pack_word(61'd99, 2'd0, 1'b0));
      send_word(pack_word(61'd100, 2'd3, 1'b1));
      send_word(pack_word(61'h0AAA_AAAA_AAAA_AAAA, 2'd1, 1'b1));
      send_word(pack_word(61'h1555_5555_5555_5555, 2'd2, 1'b0));
      send_word(pack_word(61'd1234567890, 2'd0, 1'b1));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         raw  = {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            number = raw[63:3];
         end else if (pick < 8) begin
            width  = $urandom_range(0, 61);
            number = raw[63:3] & ((61'd1 << width) - 61'd1);
         end else begin
            number = power_of_ten($urandom_range(0, 18)) - 61'($urandom_range(0, 1));
         end
         send_word(pack_word(number, raw[2:1], raw[0]));
      end
      start <= 1'b0;

      waited = 0;
      while (pending_count != 0) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d identity words (directed edges and random widths, pads and flags),",
               words_sent);
      $display("checked %0d characters after a %0d-cycle final drain.", chars_checked, waited);
      if (error_count == 0) begin
         $display("compact_id_to_decimal_text_unit_tb OK");
      end else begin
         $display("compact_id_to_decimal_text_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
